// ===== design/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and helper functions of the sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

   // request as it arrives on the input channel
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_message;
   } req_type;

   // one digest word on the result channel
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // classified request held in the queue
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       has_byte;
   } item_type;

   // queue status seen by both sides
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam logic [5:0] LAST_BYTE_POS = 6'd63;
   localparam logic [5:0] LEN_START_POS = 6'd56;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;
   localparam logic [7:0] MARKER_BYTE   = 8'h80;
   localparam logic [63:0] BYTE_BITS    = 64'd8;

   function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return rotr(x, 5'd2) ^ rotr(x, 5'd13) ^ rotr(x, 5'd22);
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return rotr(x, 5'd6) ^ rotr(x, 5'd11) ^ rotr(x, 5'd25);
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return rotr(x, 5'd7) ^ rotr(x, 5'd18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return rotr(x, 5'd17) ^ rotr(x, 5'd19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] init_hash(input logic [2:0] idx);
      logic [31:0] v;
      unique case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] idx);
      logic [31:0] k;
      unique case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

endpackage

// ===== design/sha_front.sv =====
// ----------------------------------------------------------------------------
// sha_front
// takes requests, drops empty non-final ones and hands the rest to the queue
// ----------------------------------------------------------------------------
module sha_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  sha_pkg::req_type      req,
   input  sha_pkg::q_status_type q_status,
   output logic                  push,
   output sha_pkg::item_type     push_item
);
   import sha_pkg::*;

   logic     hold_valid_ff, hold_valid_in;
   item_type hold_item_ff, hold_item_in;
   item_type classified;
   logic     accept;
   logic     drop;

   assign push      = hold_valid_ff && !q_status.full;
   assign req_stall = hold_valid_ff && q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push_item = hold_item_ff;

   // an empty request that does not end the message changes nothing
   assign drop = req.empty_message && !req.last_byte;

   always_comb begin
      classified.data_byte = req.data_byte;
      classified.last_byte = req.last_byte;
      classified.has_byte  = !req.empty_message;
   end

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_item_in  = hold_item_ff;
      if (accept) begin
         hold_valid_in = !drop;
         hold_item_in  = classified;
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_item_ff <= hold_item_in;
   end

endmodule

// ===== design/sha_queue.sv =====
// ----------------------------------------------------------------------------
// sha_queue
// short fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module sha_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sha_pkg::item_type     push_item,
   input  logic                  pop,
   output sha_pkg::item_type     pop_item,
   output sha_pkg::q_status_type q_status
);
   import sha_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign q_status.full  = count_ff == CNT_W'(DEPTH);
   assign q_status.empty = count_ff == '0;
   assign pop_item       = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/sha_back.sv =====
// ----------------------------------------------------------------------------
// sha_back
// block packing, padding sequencer, round engine and digest output
// ----------------------------------------------------------------------------
module sha_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sha_pkg::q_status_type q_status,
   input  sha_pkg::item_type     q_item,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output sha_pkg::rsp_type      rsp
);
   import sha_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ROUND,
      S_ADD,
      S_DIGEST
   } state_type;

   state_type    state_ff, state_in;
   logic [511:0] block_ff, block_in;
   logic [5:0]   pos_ff, pos_in;
   logic [63:0]  count_ff, count_in;
   logic [31:0]  hash_ff [8];
   logic [31:0]  hash_in [8];
   logic [31:0]  work_ff [8];
   logic [31:0]  work_in [8];
   logic [5:0]   round_ff, round_in;
   logic         padding_ff, padding_in;
   logic         marker_done_ff, marker_done_in;
   logic         len_phase_ff, len_phase_in;
   logic [2:0]   len_idx_ff, len_idx_in;
   logic         digest_pending_ff, digest_pending_in;
   logic [2:0]   out_idx_ff, out_idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   logic         append;
   logic [7:0]   append_byte;
   logic [7:0]   len_byte;
   logic [31:0]  w0, w1, w9, w14, w_new;
   logic [31:0]  t1, t2;
   logic         out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // schedule window: word 0 sits in the top bits
   assign w0    = block_ff[511:480];
   assign w1    = block_ff[479:448];
   assign w9    = block_ff[223:192];
   assign w14   = block_ff[63:32];
   assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;

   assign t1 = work_ff[7] + big_sigma1(work_ff[4])
             + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
             + round_k(round_ff) + w0;
   assign t2 = big_sigma0(work_ff[0])
             + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
                ^ (work_ff[1] & work_ff[2]));

   // length bytes go out most significant first
   assign len_byte = 8'(count_ff >> {3'd7 - len_idx_ff, 3'b000});

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in          = state_ff;
      block_in          = block_ff;
      pos_in            = pos_ff;
      count_in          = count_ff;
      hash_in           = hash_ff;
      work_in           = work_ff;
      round_in          = round_ff;
      padding_in        = padding_ff;
      marker_done_in    = marker_done_ff;
      len_phase_in      = len_phase_ff;
      len_idx_in        = len_idx_ff;
      digest_pending_in = digest_pending_ff;
      out_idx_in        = out_idx_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_in            = rsp_ff;
      pop               = 1'b0;
      append            = 1'b0;
      append_byte       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               if (q_item.has_byte) begin
                  append      = 1'b1;
                  append_byte = q_item.data_byte;
                  count_in    = count_ff + BYTE_BITS;
               end
               if (q_item.last_byte) begin
                  state_in          = S_PAD;
                  padding_in        = 1'b1;
                  marker_done_in    = 1'b0;
                  len_phase_in      = 1'b0;
                  len_idx_in        = '0;
                  digest_pending_in = 1'b0;
               end
            end
         end
         S_PAD: begin
            append = 1'b1;
            if (!marker_done_ff) begin
               append_byte    = MARKER_BYTE;
               marker_done_in = 1'b1;
            end else if (!len_phase_ff && pos_ff != LEN_START_POS) begin
               append_byte = '0;
            end else begin
               append_byte  = len_byte;
               len_phase_in = 1'b1;
               len_idx_in   = len_idx_ff + 1'b1;
               if (len_idx_ff == LAST_WORD_IDX) begin
                  digest_pending_in = 1'b1;
               end
            end
         end
         S_ROUND: begin
            block_in   = {block_ff[479:0], w_new};
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            round_in   = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            for (int i = 0; i < 8; i++) begin
               hash_in[i] = hash_ff[i] + work_ff[i];
            end
            if (digest_pending_ff) begin
               state_in   = S_DIGEST;
               out_idx_in = '0;
            end else if (padding_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIGEST: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.digest_word = hash_ff[out_idx_ff];
               rsp_in.word_index  = out_idx_ff;
               rsp_in.last_word   = out_idx_ff == LAST_WORD_IDX;
               out_idx_in         = out_idx_ff + 1'b1;
               if (out_idx_ff == LAST_WORD_IDX) begin
                  for (int i = 0; i < 8; i++) begin
                     hash_in[i] = init_hash(3'(i));
                  end
                  count_in          = '0;
                  padding_in        = 1'b0;
                  digest_pending_in = 1'b0;
                  state_in          = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // byte shifts in at the bottom; a full block starts the rounds
      if (append) begin
         block_in = {block_ff[503:0], append_byte};
         pos_in   = pos_ff + 1'b1;
         if (pos_ff == LAST_BYTE_POS) begin
            state_in = S_ROUND;
            work_in  = hash_ff;
            round_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         pos_ff            <= '0;
         count_ff          <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= init_hash(3'(i));
         end
         round_ff          <= '0;
         padding_ff        <= 1'b0;
         marker_done_ff    <= 1'b0;
         len_phase_ff      <= 1'b0;
         len_idx_ff        <= '0;
         digest_pending_ff <= 1'b0;
         out_idx_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         pos_ff            <= pos_in;
         count_ff          <= count_in;
         hash_ff           <= hash_in;
         round_ff          <= round_in;
         padding_ff        <= padding_in;
         marker_done_ff    <= marker_done_in;
         len_phase_ff      <= len_phase_in;
         len_idx_ff        <= len_idx_in;
         digest_pending_ff <= digest_pending_in;
         out_idx_ff        <= out_idx_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      block_ff <= block_in;
      work_ff  <= work_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ===== design/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream, eight digest words per message
// ----------------------------------------------------------------------------
// Each request carries one message byte; a request with last_byte set ends
// the message (with empty_message also set it adds no byte, and an empty
// request without last_byte is dropped). A message byte is packed into the
// block, and every 64th byte starts the 64-round compression, one round per
// cycle in a single round engine, followed by the hash update. The final
// request then adds the padding bytes (9 to 72 bytes), one or two further
// compressions and the eight digest words, h0 first, after which the hasher
// is back at its initial values. A short queue between the request front
// and the hashing back end lets requests keep arriving while a block is
// compressed or a digest is drained.
module sha256_byte_stream_hasher #(
   parameter int QUEUE_DEPTH = 4   // requests buffered ahead of the back end
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sha_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sha_pkg::rsp_type rsp
);
   import sha_pkg::*;

   // front to queue
   logic         q_push;
   item_type     q_push_item;
   // queue to back
   logic         q_pop;
   item_type     q_pop_item;
   q_status_type q_status;

   // request side: classification and hand-off
   sha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .q_status  (q_status),
      .push      (q_push),
      .push_item (q_push_item)
   );

   // decoupling queue
   sha_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .pop       (q_pop),
      .pop_item  (q_pop_item),
      .q_status  (q_status)
   );

   // hashing back end and digest output register
   sha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_item    (q_pop_item),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   // last flag marks exactly the h7 word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.last_word == (rsp.word_index == LAST_WORD_IDX)))
      else $error("last_word does not match word_index");

   // digest words follow each other without a gap, in order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp.last_word)
      |=> (rsp_valid && rsp.word_index == ($past(rsp.word_index) + 3'd1)))
      else $error("digest word sequence broken");

   // no result right after reset
   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ===== bench/sha256_bench_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_bench_pkg
// digest predictor and result scoreboard for the sha-256 byte stream bench
// ----------------------------------------------------------------------------
package sha256_bench_pkg;

   import sha_pkg::*;

   localparam logic [7:0]  PAD_MARKER     = 8'h80;
   localparam int unsigned BLOCK_BYTES    = 64;
   localparam int unsigned LENGTH_FIELD_AT = 56;
   localparam int unsigned DIGEST_WORDS   = 8;

   localparam logic [0:7][31:0] INITIAL_CHAIN = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [0:63][31:0] ROUND_CONSTANTS = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   class sha256_digest_scoreboard;

      logic [31:0] chain [8];
      logic [31:0] block [16];
      logic [63:0] bit_count;
      int unsigned fill;
      rsp_type     pending_words [$];
      int unsigned mismatches;
      int unsigned words_checked;

      function new();
         mismatches    = 0;
         words_checked = 0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) chain[i] = INITIAL_CHAIN[i];
         for (int i = 0; i < 16; i++) block[i] = '0;
         bit_count = '0;
         fill      = 0;
      endfunction

      function logic [31:0] ror32(logic [31:0] x, int unsigned n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress_block();
         logic [31:0] w [64];
         logic [31:0] a, b, c, d, e, f, g, h;
         logic [31:0] s0, s1, t1, t2;
         for (int i = 0; i < 16; i++) w[i] = block[i];
         for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
         end
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
         e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
         for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25))
                 + ((e & f) ^ (~e & g)) + ROUND_CONSTANTS[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22))
                 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e;
            e = d + t1;
            d = c; c = b; b = a;
            a = t1 + t2;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
         chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
      endfunction

      // big-endian packing, compress on every 64th byte
      function void absorb_byte(logic [7:0] value);
         int unsigned slot, lane;
         slot = fill >> 2;
         lane = fill & 3;
         if (lane == 0) block[slot] = '0;
         block[slot][31 - 8*lane -: 8] = value;
         fill++;
         if (fill == BLOCK_BYTES) begin
            compress_block();
            fill = 0;
         end
      endfunction

      function void note_request(req_type r);
         logic [63:0] length_bits;
         rsp_type     word;
         if (!r.empty_message) begin
            absorb_byte(r.data_byte);
            bit_count += 64'd8;
         end
         if (!r.last_byte) return;
         length_bits = bit_count;
         absorb_byte(PAD_MARKER);
         while (fill != LENGTH_FIELD_AT) absorb_byte(8'h00);
         for (int i = 0; i < 8; i++) absorb_byte(length_bits[63 - 8*i -: 8]);
         for (int i = 0; i < DIGEST_WORDS; i++) begin
            word.digest_word = chain[i];
            word.word_index  = 3'(i);
            word.last_word   = (i == DIGEST_WORDS - 1);
            pending_words    = {pending_words, word};
         end
         restart();
      endfunction

      function int unsigned outstanding();
         return pending_words.size();
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $time, what);
         mismatches++;
      endtask

      task check_digest(rsp_type got);
         rsp_type want;
         words_checked++;
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected digest word %h index %0d",
                                      got.digest_word, got.word_index));
            return;
         end
         want = pending_words.pop_front();
         if (got.digest_word !== want.digest_word)
            report_mismatch($sformatf("digest_word %h, want %h (index %0d)",
                                      got.digest_word, want.digest_word, want.word_index));
         if (got.word_index !== want.word_index)
            report_mismatch($sformatf("word_index %0d, want %0d",
                                      got.word_index, want.word_index));
         if (got.last_word !== want.last_word)
            report_mismatch($sformatf("last_word %b, want %b (index %0d)",
                                      got.last_word, want.last_word, want.word_index));
      endtask

   endclass

endpackage

// ===== bench/tb_sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher
// streams whole messages byte by byte into the hasher and checks every digest
// word against an independent sha-256 predictor, under random idle and stall
// on both channels
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;

   timeunit 1ns;
   timeprecision 1ps;

   import sha_pkg::*;
   import sha256_bench_pkg::*;

   // run length guards
   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned DRAIN_CYCLES   = 300;
   localparam int unsigned ITEMS_PER_PHASE = 68;

   // message lengths around the padding boundaries: one or two final blocks,
   // an exactly full block and messages reaching into a second block
   localparam int unsigned PAD_EDGE_LENGTHS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req       = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp;

   int unsigned sender_idle_pct   = 30;
   int unsigned receiver_stall_pct = 53;
   int unsigned items_sent        = 0;
   int unsigned messages_sent     = 0;
   int unsigned cycle_count       = 0;

   sha256_digest_scoreboard digests = new();

   sha256_byte_stream_hasher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   always #4 clock = ~clock;

   // hard stop in case the block hangs or loses a digest word
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d digest words still pending",
                  cycle_count, digests.outstanding());
         $display("tb_sha256_byte_stream_hasher: FAIL");
         $finish;
      end
   end

   // receiver back-pressure, redrawn every cycle at the falling edge
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
   end

   // result monitor: a digest word moves on a rising edge with valid and no stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         digests.check_digest(rsp);
   end

   function automatic req_type make_request(logic [7:0] data, logic last, logic empty);
      req_type r;
      r.data_byte     = data;
      r.last_byte     = last;
      r.empty_message = empty;
      return r;
   endfunction

   // called and returns at a falling edge; valid stays high after acceptance so
   // back-to-back requests need no second assignment in the same step
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req       <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      digests.note_request(r);
      // every accepted request counts, stray empty ones included
      items_sent++;
      if (r.last_byte) messages_sent++;
      @(negedge clock);
   endtask

   // sender pauses with valid low until every pending digest word has come back
   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (digests.outstanding() != 0) @(negedge clock);
   endtask

   // one message with random bytes, a few stray empty requests mixed in, ended
   // either by a final byte or by an empty final request
   task automatic send_random_message(input bit at_pad_edge);
      int unsigned len;
      bit          end_empty;
      if (at_pad_edge || $urandom_range(99) < 8)
         len = PAD_EDGE_LENGTHS[$urandom_range(7)];
      else
         len = $urandom_range(12);
      end_empty = (len == 0) || ($urandom_range(99) < 30);
      for (int unsigned k = 0; k < len; k++) begin
         if ($urandom_range(99) < 8)
            send_request(make_request(8'($urandom), 1'b0, 1'b1));
         send_request(make_request(8'($urandom), !end_empty && (k == len - 1), 1'b0));
      end
      if (end_empty)
         send_request(make_request(8'($urandom), 1'b1, 1'b1));
   endtask

   initial begin
      int unsigned phase_target;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty message right after reset
      send_request(make_request(8'hff, 1'b1, 1'b1));
      // "abc", the classic one-block vector
      send_request(make_request(8'h61, 1'b0, 1'b0));
      send_request(make_request(8'h62, 1'b0, 1'b0));
      send_request(make_request(8'h63, 1'b1, 1'b0));
      // extreme byte values, final byte carrying data
      send_request(make_request(8'h00, 1'b0, 1'b0));
      send_request(make_request(8'hff, 1'b1, 1'b0));
      send_request(make_request(8'hff, 1'b1, 1'b0));
      send_request(make_request(8'h00, 1'b1, 1'b0));
      // stray empty request inside a message, then an empty final request
      send_request(make_request(8'hff, 1'b0, 1'b1));
      send_request(make_request(8'h55, 1'b0, 1'b0));
      send_request(make_request(8'h00, 1'b0, 1'b1));
      send_request(make_request(8'haa, 1'b1, 1'b1));
      // stray empty request before a message starts, then an empty message
      send_request(make_request(8'h5a, 1'b0, 1'b1));
      send_request(make_request(8'h00, 1'b1, 1'b1));

      // random part in three idle/stall phases, each opening at a padding edge
      phase_target = items_sent;
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               sender_idle_pct    = 30;
               receiver_stall_pct = 53;
            end
            1: begin
               sender_idle_pct    = 53;
               receiver_stall_pct = 30;
            end
            default: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
         endcase
         if (phase != 0) hold_until_drained();
         phase_target += ITEMS_PER_PHASE;
         send_random_message(1'b1);
         while (items_sent < phase_target) send_random_message(1'b0);
      end

      // wait out the last digest, then watch for stray results
      req_valid <= 1'b0;
      while (digests.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests in %0d messages, %0d digest words checked, %0d mismatches",
               items_sent, messages_sent, digests.words_checked, digests.mismatches);
      $display("covered empty messages, stray empty requests, one and two pad blocks, "
               , "full-block lengths, idle and stall on both sides");
      if (digests.mismatches == 0)
         $display("tb_sha256_byte_stream_hasher: PASS");
      else
         $display("tb_sha256_byte_stream_hasher: FAIL");
      $finish;
   end

endmodule
